// File: design/fpba_pkg.sv
// ----------------------------------------------------------------------------
// fpba_pkg
// shared constants for the fit policy block allocator: field widths,
// configuration register indexes, policy and request codes
// ----------------------------------------------------------------------------
package fpba_pkg;

	localparam int NUM_BLOCKS_DEF = 16;
	localparam int SIZE_BITS_DEF  = 16;

	localparam int FIELD_SIZE_W = 16;
	localparam int FIELD_IDX_W  = 4;
	localparam int MODE_W       = 2;
	localparam int COUNT_W      = 5;
	localparam int CFG_IDX_W    = 1;
	localparam int CFG_DATA_W   = 5;

	localparam logic [CFG_IDX_W-1:0] CFG_FIT_MODE    = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_COUNT = 1'd1;

	localparam logic [MODE_W-1:0] FIT_FIRST = 2'd0;
	localparam logic [MODE_W-1:0] FIT_BEST  = 2'd1;
	localparam logic [MODE_W-1:0] FIT_WORST = 2'd2;

	localparam logic [MODE_W-1:0]  FIT_MODE_RST    = FIT_FIRST;
	localparam logic [COUNT_W-1:0] BLOCK_COUNT_RST = 5'd16;

	localparam logic REQ_LOAD  = 1'b0;
	localparam logic REQ_ALLOC = 1'b1;

endpackage

// File: design/fit_policy_block_allocator.sv
// ----------------------------------------------------------------------------
// fit_policy_block_allocator
// keeps a table of free block sizes and serves allocate requests by first,
// best or worst fit, one entry compared per cycle
// ----------------------------------------------------------------------------
//  channel  | handshake                | payload
//  item     | item_valid / item_stall  | req_type, entry_index, size_value
//  result   | result_valid/result_stall| granted, chosen_index, remaining_size
//  cfg      | cfg_valid / cfg_ready    | cfg_index, cfg_data
//
//  a load request writes its table entry and gives no result
//  an allocate request scans block_count entries (at most NUM_BLOCKS), one table read per cycle
//  through the single compare unit, then takes one last compare, one end check and one
//  writeback before its result is registered
//  item_stall is high from accept of an allocate until its result is registered
//  a stalled result holds the writeback cycle until the output register is free
//  arst_n clears control and configuration; the size table is not cleared
// ----------------------------------------------------------------------------
module fit_policy_block_allocator #(
	parameter int NUM_BLOCKS = fpba_pkg::NUM_BLOCKS_DEF,
	parameter int SIZE_BITS  = fpba_pkg::SIZE_BITS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               item_valid,
	output logic                               item_stall,
	input  logic                               req_type,
	input  logic [fpba_pkg::FIELD_IDX_W-1:0]   entry_index,
	input  logic [fpba_pkg::FIELD_SIZE_W-1:0]  size_value,
	output logic                               result_valid,
	input  logic                               result_stall,
	output logic                               granted,
	output logic [fpba_pkg::FIELD_IDX_W-1:0]   chosen_index,
	output logic [fpba_pkg::FIELD_SIZE_W-1:0]  remaining_size,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [fpba_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [fpba_pkg::CFG_DATA_W-1:0]    cfg_data
);

	localparam int IDX_W = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
	localparam int CNT_W = $clog2(NUM_BLOCKS + 1);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_FINISH
	} state_t;

	state_t                          state_q;
	logic [fpba_pkg::MODE_W-1:0]     fit_mode_q;
	logic [fpba_pkg::COUNT_W-1:0]    block_count_q;
	logic [SIZE_BITS-1:0]            mem [NUM_BLOCKS];
	logic [SIZE_BITS-1:0]            rd_data_s1;
	logic [IDX_W-1:0]                rd_idx_s1;
	logic                            rd_vld_s1;
	logic [CNT_W-1:0]                ptr_q;
	logic [CNT_W-1:0]                limit_q;
	logic [CNT_W-1:0]                limit_in;
	logic [SIZE_BITS-1:0]            req_q;
	logic [SIZE_BITS-1:0]            best_q;
	logic [IDX_W-1:0]                pick_q;
	logic                            found_q;
	logic [SIZE_BITS-1:0]            size_in;
	logic                            item_acc;
	logic                            out_free;
	logic                            fits;
	logic                            better;
	logic                            mem_we;
	logic [IDX_W-1:0]                mem_waddr;
	logic [SIZE_BITS-1:0]            mem_wdata;
	logic [SIZE_BITS-1:0]            remain;

	assign size_in    = SIZE_BITS'(size_value);
	assign item_stall = (state_q != ST_IDLE);
	assign item_acc   = item_valid && !item_stall;
	assign out_free   = !result_valid || !result_stall;
	assign cfg_ready  = 1'b1;
	assign remain     = best_q - req_q;
	assign limit_in   = (32'(block_count_q) > NUM_BLOCKS) ? CNT_W'(NUM_BLOCKS)
	                                                       : CNT_W'(block_count_q);

	// compare unit
	assign fits = (rd_data_s1 >= req_q);
	always_comb begin
		case (fit_mode_q)
			fpba_pkg::FIT_FIRST: better = 1'b0;
			fpba_pkg::FIT_BEST:  better = (rd_data_s1 < best_q);
			fpba_pkg::FIT_WORST: better = (rd_data_s1 > best_q);
			default:             better = 1'b0;
		endcase
	end

	// table write port
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = pick_q;
		mem_wdata = remain;
		if (item_acc && req_type == fpba_pkg::REQ_LOAD) begin
			mem_we    = (32'(entry_index) < NUM_BLOCKS);
			mem_waddr = IDX_W'(entry_index);
			mem_wdata = size_in;
		end else if (state_q == ST_FINISH && out_free && found_q) begin
			mem_we = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		rd_data_s1 <= mem[ptr_q[IDX_W-1:0]];
		rd_idx_s1  <= ptr_q[IDX_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fit_mode_q    <= fpba_pkg::FIT_MODE_RST;
			block_count_q <= fpba_pkg::BLOCK_COUNT_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				fpba_pkg::CFG_FIT_MODE:    fit_mode_q    <= cfg_data[fpba_pkg::MODE_W-1:0];
				fpba_pkg::CFG_BLOCK_COUNT: block_count_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			rd_vld_s1      <= 1'b0;
			ptr_q          <= '0;
			limit_q        <= '0;
			found_q        <= 1'b0;
			result_valid   <= 1'b0;
			req_q          <= '0;
			best_q         <= '0;
			pick_q         <= '0;
			granted        <= 1'b0;
			chosen_index   <= '0;
			remaining_size <= '0;
		end else begin
			if (result_valid && !result_stall && state_q != ST_FINISH) begin
				result_valid <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					rd_vld_s1 <= 1'b0;
					if (item_acc && req_type == fpba_pkg::REQ_ALLOC) begin
						req_q   <= size_in;
						limit_q <= limit_in;
						ptr_q   <= '0;
						found_q <= 1'b0;
						pick_q  <= '0;
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					// issue next read
					if (ptr_q < limit_q) begin
						rd_vld_s1 <= 1'b1;
						ptr_q     <= ptr_q + CNT_W'(1);
					end else begin
						rd_vld_s1 <= 1'b0;
					end
					// compare returned entry
					if (rd_vld_s1 && fits && (!found_q || better)) begin
						found_q <= 1'b1;
						best_q  <= rd_data_s1;
						pick_q  <= rd_idx_s1;
					end
					if (ptr_q == limit_q && !rd_vld_s1) begin
						state_q <= ST_FINISH;
					end
				end
				ST_FINISH: begin
					if (out_free) begin
						result_valid   <= 1'b1;
						granted        <= found_q;
						chosen_index   <= found_q ? fpba_pkg::FIELD_IDX_W'(pick_q) : '0;
						remaining_size <= found_q ? fpba_pkg::FIELD_SIZE_W'(remain) : '0;
						state_q        <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	a_busy_stalls: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN || state_q == ST_FINISH) |-> item_stall)
		else $error("item accepted during allocation");

	a_result_from_finish: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |-> $past(state_q == ST_FINISH))
		else $error("result raised outside finish");

	a_deny_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && !granted) |-> (chosen_index == '0 && remaining_size == '0))
		else $error("denied result carries nonzero fields");

	a_ptr_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN) |-> (ptr_q <= limit_q))
		else $error("scan pointer beyond limit");

	a_scan_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN && ptr_q == limit_q && !rd_vld_s1) |=> (state_q == ST_FINISH))
		else $error("scan did not end");

endmodule
